// ===== rtl/lmd2x2_pkg.sv =====
// shared types, constants and the block-mode function for the 2x2 label mode downsampler
package lmd2x2_pkg;

	localparam int MAX_WIDTH = 4096;
	localparam int LABEL_BITS = 8;
	localparam int CFG_BITS = 13;
	localparam int COL_BITS = $clog2(MAX_WIDTH);
	localparam int ROW_BITS = CFG_BITS;
	localparam int PAIR_DEPTH = MAX_WIDTH / 2;
	localparam int PAIR_ADDR_BITS = $clog2(PAIR_DEPTH);
	localparam int PAIR_BITS = 2 * LABEL_BITS;
	localparam int CFG_INDEX_BITS = 1;

	localparam logic [CFG_BITS-1:0] MIN_SIZE = CFG_BITS'(2);
	localparam logic [CFG_BITS-1:0] MAX_SIZE = CFG_BITS'(MAX_WIDTH);
	localparam logic [CFG_BITS-1:0] RESET_SIZE = CFG_BITS'(4096);

	typedef logic [LABEL_BITS-1:0] label_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	// one finished 2x2 block waiting for the mode logic
	typedef struct packed {
		label_t tl;
		label_t tr;
		label_t bl;
		label_t br;
		logic   eor;
		logic   eof;
	} blk_t;

	// most frequent of four labels; the earliest label to reach the top count wins
	function automatic label_t mode4(input label_t a, input label_t b, input label_t c,
		input label_t d);
		label_t     best;
		logic [2:0] best_cnt;
		logic [2:0] cnt;
		best = a;
		best_cnt = 3'd1;
		cnt = 3'd1 + {2'b00, a == b};
		if (cnt > best_cnt) begin
			best_cnt = cnt;
			best = b;
		end
		cnt = 3'd1 + {2'b00, a == c} + {2'b00, b == c};
		if (cnt > best_cnt) begin
			best_cnt = cnt;
			best = c;
		end
		cnt = 3'd1 + {2'b00, a == d} + {2'b00, b == d} + {2'b00, c == d};
		if (cnt > best_cnt) begin
			best = d;
		end
		return best;
	endfunction

endpackage

// ===== rtl/lmd2x2_ram.sv =====
// generic simple dual-port ram with registered read
module lmd2x2_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/label_mode_downsample_2x2.sv =====
// Takes one label per clock while not stalled, in raster order, and gives one label per
// 2x2 block: the most frequent of top-left, top-right, bottom-left, bottom-right, the
// earliest to reach the top count winning a tie. The beat with the bottom-right pixel
// passes through the block register, then the mode stage into the output register.
// The upper row of each row pair sits in a 2048 x 16 pair ram, one column pair per word:
// written once per pair on even rows, read once per pair on odd rows when the left pixel
// arrives, so the ram port is never shared and a pixel can be taken on every clock that
// pixel_stall is low. The ram needs no clearing after reset. A trailing odd column or
// row is consumed without output. Writing either size register restarts the frame;
// sizes are clamped to 2..4096 for width and at least 2 for height.
module label_mode_downsample_2x2 (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_we,
	input  logic [lmd2x2_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [lmd2x2_pkg::CFG_BITS-1:0]          cfg_data,
	input  logic                                     pixel_valid,
	output logic                                     pixel_stall,
	input  lmd2x2_pkg::label_t                       pixel_label,
	output logic                                     block_valid,
	input  logic                                     block_stall,
	output lmd2x2_pkg::label_t                       mode_label,
	output logic                                     end_of_row,
	output logic                                     end_of_frame
);

	logic [lmd2x2_pkg::COL_BITS-1:0] col_q;
	logic [lmd2x2_pkg::ROW_BITS-1:0] row_q;
	logic [lmd2x2_pkg::COL_BITS-1:0] wlast_q;
	logic [lmd2x2_pkg::COL_BITS-1:0] wpair_last_q;
	logic [lmd2x2_pkg::ROW_BITS-1:0] hlast_q;
	logic [lmd2x2_pkg::ROW_BITS-1:0] hpair_last_q;
	lmd2x2_pkg::label_t              left_q;

	logic                            v_s1;
	lmd2x2_pkg::blk_t                blk_s1;
	logic                            v_s2;
	lmd2x2_pkg::label_t              mode_s2;
	logic                            eor_s2;
	logic                            eof_s2;

	logic                            adv;
	logic                            pix_acc;
	logic                            ram_we;
	logic                            ram_re;
	logic                            res;
	logic [lmd2x2_pkg::PAIR_BITS-1:0] pair_rdata;
	lmd2x2_pkg::blk_t                blk_next;

	logic [lmd2x2_pkg::CFG_BITS-1:0] w_eff;
	logic [lmd2x2_pkg::CFG_BITS-1:0] h_eff;
	logic [lmd2x2_pkg::CFG_BITS-1:0] w_pair_m1;
	logic [lmd2x2_pkg::CFG_BITS-1:0] h_pair_m1;
	logic [lmd2x2_pkg::CFG_BITS-1:0] w_m1;
	logic [lmd2x2_pkg::CFG_BITS-1:0] h_m1;

	// size clamping happens once, at the register write
	always_comb begin
		if (cfg_data < lmd2x2_pkg::MIN_SIZE) begin
			w_eff = lmd2x2_pkg::MIN_SIZE;
		end else if (cfg_data > lmd2x2_pkg::MAX_SIZE) begin
			w_eff = lmd2x2_pkg::MAX_SIZE;
		end else begin
			w_eff = cfg_data;
		end
		if (cfg_data < lmd2x2_pkg::MIN_SIZE) begin
			h_eff = lmd2x2_pkg::MIN_SIZE;
		end else begin
			h_eff = cfg_data;
		end
		w_m1 = w_eff - lmd2x2_pkg::CFG_BITS'(1);
		h_m1 = h_eff - lmd2x2_pkg::CFG_BITS'(1);
		w_pair_m1 = {w_eff[lmd2x2_pkg::CFG_BITS-1:1], 1'b0} - lmd2x2_pkg::CFG_BITS'(1);
		h_pair_m1 = {h_eff[lmd2x2_pkg::CFG_BITS-1:1], 1'b0} - lmd2x2_pkg::CFG_BITS'(1);
	end

	assign adv = !v_s2 || !block_stall;
	assign pixel_stall = v_s1 && !adv;
	assign pix_acc = pixel_valid && !pixel_stall;

	assign ram_we = pix_acc && !row_q[0] && col_q[0];
	assign ram_re = pix_acc && row_q[0] && !col_q[0];
	assign res = pix_acc && row_q[0] && col_q[0] && (col_q <= wpair_last_q);

	lmd2x2_ram #(
		.WIDTH(lmd2x2_pkg::PAIR_BITS),
		.DEPTH(lmd2x2_pkg::PAIR_DEPTH)
	) u_top_row (
		.clk  (clk),
		.we   (ram_we),
		.waddr(col_q[lmd2x2_pkg::COL_BITS-1:1]),
		.wdata({left_q, pixel_label}),
		.re   (ram_re),
		.raddr(col_q[lmd2x2_pkg::COL_BITS-1:1]),
		.rdata(pair_rdata)
	);

	always_comb begin
		blk_next.tl = pair_rdata[lmd2x2_pkg::PAIR_BITS-1:lmd2x2_pkg::LABEL_BITS];
		blk_next.tr = pair_rdata[lmd2x2_pkg::LABEL_BITS-1:0];
		blk_next.bl = left_q;
		blk_next.br = pixel_label;
		blk_next.eor = (col_q == wpair_last_q);
		blk_next.eof = (col_q == wpair_last_q) && (row_q == hpair_last_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			wlast_q <= lmd2x2_pkg::COL_BITS'(lmd2x2_pkg::RESET_SIZE - 1);
			wpair_last_q <= lmd2x2_pkg::COL_BITS'(lmd2x2_pkg::RESET_SIZE - 1);
			hlast_q <= lmd2x2_pkg::ROW_BITS'(lmd2x2_pkg::RESET_SIZE - 1);
			hpair_last_q <= lmd2x2_pkg::ROW_BITS'(lmd2x2_pkg::RESET_SIZE - 1);
			left_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (cfg_we) begin
				col_q <= '0;
				row_q <= '0;
				if (cfg_index == lmd2x2_pkg::REG_IMAGE_WIDTH) begin
					wlast_q <= w_m1[lmd2x2_pkg::COL_BITS-1:0];
					wpair_last_q <= w_pair_m1[lmd2x2_pkg::COL_BITS-1:0];
				end else begin
					hlast_q <= h_m1;
					hpair_last_q <= h_pair_m1;
				end
			end else if (pix_acc) begin
				if (col_q == wlast_q) begin
					col_q <= '0;
					row_q <= (row_q == hlast_q) ? '0 : row_q + lmd2x2_pkg::ROW_BITS'(1);
				end else begin
					col_q <= col_q + lmd2x2_pkg::COL_BITS'(1);
				end
			end
			// left pixel of a pair: top pair staging on even rows, bottom-left on odd rows
			if (pix_acc && !col_q[0]) begin
				left_q <= pixel_label;
			end
			if (adv || !v_s1) begin
				v_s1 <= res;
			end
			if (adv) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res) begin
			blk_s1 <= blk_next;
		end
		if (adv && v_s1) begin
			mode_s2 <= lmd2x2_pkg::mode4(blk_s1.tl, blk_s1.tr, blk_s1.bl, blk_s1.br);
			eor_s2 <= blk_s1.eor;
			eof_s2 <= blk_s1.eof;
		end
	end

	assign block_valid = v_s2;
	assign mode_label = mode_s2;
	assign end_of_row = eor_s2;
	assign end_of_frame = eof_s2;

endmodule

// ===== rtl/lmd2x2_checker.sv =====
// port-level checks for the 2x2 label mode downsampler, bound to the top level
module lmd2x2_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               pixel_valid,
	input logic               pixel_stall,
	input lmd2x2_pkg::label_t pixel_label,
	input logic               block_valid,
	input logic               block_stall,
	input lmd2x2_pkg::label_t mode_label,
	input logic               end_of_row,
	input logic               end_of_frame
);

	// a stalled input beat holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel_label))
		else $error("stalled input beat changed");

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		block_valid && block_stall |=> block_valid && $stable(mode_label)
			&& $stable(end_of_row) && $stable(end_of_frame))
		else $error("stalled result beat changed");

	// input backpressure only comes from a stalled output
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall |-> block_valid && block_stall)
		else $error("pixel stall without output stall");

	// the last block of a frame always closes an output row
	a_eof_eor: assert property (@(posedge clk) disable iff (!arst_n)
		block_valid && end_of_frame |-> end_of_row)
		else $error("end of frame without end of row");

endmodule

bind label_mode_downsample_2x2 lmd2x2_checker u_lmd2x2_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.pixel_valid (pixel_valid),
	.pixel_stall (pixel_stall),
	.pixel_label (pixel_label),
	.block_valid (block_valid),
	.block_stall (block_stall),
	.mode_label  (mode_label),
	.end_of_row  (end_of_row),
	.end_of_frame(end_of_frame)
);

// ===== sim/tb_top.sv =====
// testbench for the 2x2 label mode downsampler: directed and random streams checked per beat
module tb_top;

	localparam int DRAIN_CYCLES = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 1040;

	typedef struct packed {
		lmd2x2_pkg::label_t label;
		logic               eor;
		logic               eof;
	} mode_beat_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_we = 1'b0;
	lmd2x2_pkg::cfg_reg_t            cfg_index = lmd2x2_pkg::REG_IMAGE_WIDTH;
	logic [lmd2x2_pkg::CFG_BITS-1:0] cfg_data = '0;
	logic                            pixel_valid = 1'b0;
	logic                            pixel_stall;
	lmd2x2_pkg::label_t              pixel_label = '0;
	logic                            block_valid;
	logic                            block_stall = 1'b0;
	lmd2x2_pkg::label_t              mode_label;
	logic                            end_of_row;
	logic                            end_of_frame;

	// block model state
	lmd2x2_pkg::label_t              upper_row [lmd2x2_pkg::MAX_WIDTH];
	lmd2x2_pkg::label_t              lower_left = '0;
	int                              col_pos = 0;
	int                              row_pos = 0;
	logic [lmd2x2_pkg::CFG_BITS-1:0] width_reg = lmd2x2_pkg::RESET_SIZE;
	logic [lmd2x2_pkg::CFG_BITS-1:0] height_reg = lmd2x2_pkg::RESET_SIZE;
	mode_beat_t                      expected_modes [$];

	int                 error_count = 0;
	int                 idle_cycles = 0;
	int                 stall_left = 0;
	int                 in_gap_max = 0;
	int                 out_stall_max = 0;
	lmd2x2_pkg::label_t palette [4];

	// tl, tr, bl, br of each block in the tie-rule frame
	lmd2x2_pkg::label_t tie_blocks [6][4] = '{
		'{8'h00, 8'h00, 8'h00, 8'h00},
		'{8'hff, 8'hff, 8'hff, 8'hff},
		'{8'h01, 8'h02, 8'h03, 8'h04},
		'{8'h07, 8'h09, 8'h09, 8'h07},
		'{8'h03, 8'h05, 8'h05, 8'h05},
		'{8'h80, 8'h7f, 8'h01, 8'h7f}
	};

	label_mode_downsample_2x2 u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel_label  (pixel_label),
		.block_valid  (block_valid),
		.block_stall  (block_stall),
		.mode_label   (mode_label),
		.end_of_row   (end_of_row),
		.end_of_frame (end_of_frame)
	);

	always #2 clk = ~clk;

	function automatic int eff_width();
		if (width_reg < lmd2x2_pkg::MIN_SIZE) return 2;
		if (width_reg > lmd2x2_pkg::MAX_SIZE) return lmd2x2_pkg::MAX_WIDTH;
		return int'(width_reg);
	endfunction

	function automatic int eff_height();
		if (height_reg < lmd2x2_pkg::MIN_SIZE) return 2;
		return int'(height_reg);
	endfunction

	// running count per position; a label wins only when it beats the best count so far
	function automatic lmd2x2_pkg::label_t mode_of_block(input lmd2x2_pkg::label_t tl,
		input lmd2x2_pkg::label_t tr, input lmd2x2_pkg::label_t bl,
		input lmd2x2_pkg::label_t br);
		lmd2x2_pkg::label_t q [4];
		lmd2x2_pkg::label_t best;
		int                 best_cnt;
		int                 cnt;
		q[0] = tl;
		q[1] = tr;
		q[2] = bl;
		q[3] = br;
		best = tl;
		best_cnt = 1;
		for (int i = 1; i < 4; i++) begin
			cnt = 0;
			for (int j = 0; j <= i; j++) begin
				if (q[j] == q[i]) cnt++;
			end
			if (cnt > best_cnt) begin
				best_cnt = cnt;
				best = q[i];
			end
		end
		return best;
	endfunction

	function automatic void track_pixel(input lmd2x2_pkg::label_t px);
		int         w_eff;
		int         h_eff;
		int         w_even;
		int         h_even;
		mode_beat_t beat;
		w_eff = eff_width();
		h_eff = eff_height();
		w_even = w_eff & ~1;
		h_even = h_eff & ~1;
		if (row_pos % 2 == 0) begin
			upper_row[col_pos] = px;
		end else if (col_pos % 2 == 0) begin
			lower_left = px;
		end else if (col_pos < w_even) begin
			beat.label = mode_of_block(upper_row[col_pos-1], upper_row[col_pos],
				lower_left, px);
			beat.eor = (col_pos == w_even - 1);
			beat.eof = beat.eor && (row_pos == h_even - 1);
			expected_modes.insert(expected_modes.size(), beat);
		end
		col_pos++;
		if (col_pos >= w_eff) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= h_eff) row_pos = 0;
		end
	endfunction

	function automatic lmd2x2_pkg::label_t draw_label();
		if ($urandom_range(0, 1) == 1) return palette[$urandom_range(0, 3)];
		return lmd2x2_pkg::label_t'($urandom);
	endfunction

	// result side: check each accepted beat against the oldest prediction, then draw a random stall
	always @(posedge clk) begin : check_blocks
		mode_beat_t want;
		if (block_valid && !block_stall) begin
			if (expected_modes.size() == 0) begin
				if (error_count < 10)
					$display("unexpected beat: label=%0d eor=%0b eof=%0b",
						mode_label, end_of_row, end_of_frame);
				error_count++;
			end else begin
				want = expected_modes.pop_front();
				if (mode_label !== want.label || end_of_row !== want.eor ||
					end_of_frame !== want.eof) begin
					if (error_count < 10)
						$display("mismatch: exp %0d/%0b/%0b got %0d/%0b/%0b",
							want.label, want.eor, want.eof,
							mode_label, end_of_row, end_of_frame);
					error_count++;
				end
			end
			stall_left = $urandom_range(out_stall_max);
		end
		block_stall <= (stall_left != 0);
		if (stall_left != 0) stall_left--;
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((pixel_valid && !pixel_stall) || (block_valid && !block_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_pixel(input lmd2x2_pkg::label_t px);
		int gap;
		gap = $urandom_range(in_gap_max);
		if (gap != 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel_valid <= 1'b1;
		pixel_label <= px;
		@(posedge clk);
		while (pixel_stall) @(posedge clk);
		track_pixel(px);
	endtask

	// drop valid, wait for every predicted beat, then let the pipeline empty
	task automatic settle();
		pixel_valid <= 1'b0;
		while (expected_modes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input lmd2x2_pkg::cfg_reg_t idx,
		input logic [lmd2x2_pkg::CFG_BITS-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		if (idx == lmd2x2_pkg::REG_IMAGE_WIDTH) width_reg = value;
		else height_reg = value;
		// any size write restarts the frame
		col_pos = 0;
		row_pos = 0;
	endtask

	task automatic configure(input bit set_w, input logic [lmd2x2_pkg::CFG_BITS-1:0] w,
		input bit set_h, input logic [lmd2x2_pkg::CFG_BITS-1:0] h);
		if (set_w) write_reg(lmd2x2_pkg::REG_IMAGE_WIDTH, w);
		if (set_h) write_reg(lmd2x2_pkg::REG_IMAGE_HEIGHT, h);
		cfg_we <= 1'b0;
	endtask

	// count of zero picks a random length from the frame size
	task automatic run_phase(input bit set_w, input logic [lmd2x2_pkg::CFG_BITS-1:0] w,
		input bit set_h, input logic [lmd2x2_pkg::CFG_BITS-1:0] h, input int count);
		int n;
		int pixels;
		configure(set_w, w, set_h, h);
		for (int i = 0; i < 4; i++) palette[i] = lmd2x2_pkg::label_t'($urandom);
		if ($urandom_range(0, 3) == 0) begin
			palette[0] = '0;
			palette[1] = '1;
		end
		n = count;
		if (n <= 0) begin
			pixels = eff_width() * eff_height();
			if ($urandom_range(0, 3) == 0) n = $urandom_range(1, pixels);
			else n = pixels * $urandom_range(1, 2) + $urandom_range(0, eff_width());
			if (n > 300) n = 300;
		end
		for (int i = 0; i < n; i++) send_pixel(draw_label());
		settle();
	endtask

	// reset size is too wide for a block to finish here, so nothing may come out
	task automatic test_reset_size();
		in_gap_max = 1;
		out_stall_max = 1;
		for (int i = 0; i < 4; i++) palette[i] = lmd2x2_pkg::label_t'($urandom);
		for (int i = 0; i < 150; i++) send_pixel(draw_label());
		settle();
	endtask

	task automatic test_tie_rules();
		in_gap_max = 16;
		out_stall_max = 16;
		configure(1'b1, lmd2x2_pkg::CFG_BITS'(12), 1'b1, lmd2x2_pkg::CFG_BITS'(2));
		for (int b = 0; b < 6; b++) begin
			send_pixel(tie_blocks[b][0]);
			send_pixel(tie_blocks[b][1]);
		end
		for (int b = 0; b < 6; b++) begin
			send_pixel(tie_blocks[b][2]);
			send_pixel(tie_blocks[b][3]);
		end
		settle();
	endtask

	task automatic test_size_extremes();
		in_gap_max = 16;
		out_stall_max = 16;
		run_phase(1'b1, lmd2x2_pkg::CFG_BITS'(0), 1'b1, lmd2x2_pkg::CFG_BITS'(0), 8);
		run_phase(1'b1, lmd2x2_pkg::CFG_BITS'(1), 1'b1, lmd2x2_pkg::CFG_BITS'(1), 8);
		run_phase(1'b1, lmd2x2_pkg::CFG_BITS'(5), 1'b1, lmd2x2_pkg::CFG_BITS'(3), 30);
		run_phase(1'b1, lmd2x2_pkg::CFG_BITS'(3), 1'b0, lmd2x2_pkg::CFG_BITS'(0), 18);
		run_phase(1'b0, lmd2x2_pkg::CFG_BITS'(0), 1'b1, lmd2x2_pkg::CFG_BITS'(7), 24);
		// clamped widest row and the tallest frame, with light idling
		in_gap_max = 1;
		out_stall_max = 1;
		run_phase(1'b1, lmd2x2_pkg::CFG_BITS'(8191), 1'b1, lmd2x2_pkg::CFG_BITS'(2), 150);
		run_phase(1'b1, lmd2x2_pkg::CFG_BITS'(2), 1'b1, lmd2x2_pkg::CFG_BITS'(8191), 300);
	endtask

	task automatic test_random_frames();
		int                              sent;
		int                              pick;
		bit                              set_w;
		bit                              set_h;
		logic [lmd2x2_pkg::CFG_BITS-1:0] w;
		logic [lmd2x2_pkg::CFG_BITS-1:0] h;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 7) == 0) w = lmd2x2_pkg::CFG_BITS'($urandom_range(0, 80));
			else w = lmd2x2_pkg::CFG_BITS'($urandom_range(0, 12));
			if ($urandom_range(0, 7) == 0) h = lmd2x2_pkg::CFG_BITS'($urandom_range(0, 12));
			else h = lmd2x2_pkg::CFG_BITS'($urandom_range(0, 6));
			pick = $urandom_range(0, 3);
			set_w = (pick != 1) || (sent == 0);
			set_h = (pick != 0) || (sent == 0);
			pick = $urandom_range(0, 2);
			in_gap_max = (pick == 0) ? 0 : (pick == 1) ? 3 : 16;
			pick = $urandom_range(0, 2);
			out_stall_max = (pick == 0) ? 0 : (pick == 1) ? 3 : 16;
			if (set_w) width_reg = w;
			if (set_h) height_reg = h;
			// rough length estimate for the budget only
			sent += (eff_width() * eff_height() > 300) ? 300 : eff_width() * eff_height() + 1;
			run_phase(set_w, w, set_h, h, 0);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_size();
		test_tie_rules();
		test_size_extremes();
		test_random_frames();
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
